// File: rtl/spp_pkg.sv
// Types, constants and helper functions shared by the spherical patch point pipeline.
package spp_pkg;

  localparam int ATAN_N      = 24;
  localparam int ANG_W       = 22;  // Q3.16 angle after reduction, with sign headroom
  localparam int CW          = 34;  // CORDIC datapath width (Q2.30 plus headroom)
  localparam int ANG_PI      = 205887;
  localparam int ANG_TWO_PI  = 411775;
  localparam int ANG_HALF_PI = 102944;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam int ONE_Q14     = 16384;
  localparam int PT_MAX      = 1048575;
  localparam int PT_MIN      = -1048576;

  localparam logic [2:0] REG_CENTER = 3'd0;
  localparam logic [2:0] REG_NORMAL = 3'd1;
  localparam logic [2:0] REG_AXIS1  = 3'd2;
  localparam logic [2:0] REG_AXIS2  = 3'd3;
  localparam logic [2:0] REG_RADIUS = 3'd4;
  localparam logic [2:0] REG_AZ_EXT = 3'd5;
  localparam logic [2:0] REG_PO_EXT = 3'd6;

  typedef logic signed [CW-1:0] cval_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    cval_t z;
    logic  neg;
  } cstate_t;

  function automatic cval_t atan_q30(input int i);
    cval_t r;
    r = '0;
    case (i)
      0: r = 34'sd843314856;
      1: r = 34'sd497837829;
      2: r = 34'sd263043836;
      3: r = 34'sd133525158;
      4: r = 34'sd67021686;
      5: r = 34'sd33543515;
      6: r = 34'sd16775850;
      7: r = 34'sd8388437;
      8: r = 34'sd4194282;
      9: r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round half up from Q2.30 to Q1.14, clamp to unit
  function automatic logic signed [15:0] to_unit(input cval_t v);
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] r;
    t = v + cval_t'(32768);
    r = t >>> 16;
    if (r > cval_t'(ONE_Q14)) return 16'sd16384;
    if (r < -cval_t'(ONE_Q14)) return -16'sd16384;
    return r[15:0];
  endfunction

endpackage

// File: rtl/spp_angle.sv
// Angle formation, range reduction and fold into CORDIC start state (two stages).
module spp_angle
  import spp_pkg::*;
#(
  parameter int EXT_W = 19
) (
  input  logic             clk,
  input  logic             en,
  input  logic [16:0]      frac,
  input  logic [EXT_W-1:0] ext,
  output cstate_t          st
);

  logic signed [37:0] prod_r, prod_nxt;
  cstate_t            st_r, st_nxt;
  logic signed [37:0] ang;
  logic signed [ANG_W-1:0] a;

  always_comb begin
    prod_nxt = (38'($signed({1'b0, frac})) - 38'sd32768) * $signed({19'd0, ext});
  end

  always_comb begin
    ang = (prod_r + 38'sd32768) >>> 16;
    a = ang[ANG_W-1:0];
    if (a > ANG_W'(ANG_PI)) a = a - ANG_W'(ANG_TWO_PI);
    else if (a < -ANG_W'(ANG_PI)) a = a + ANG_W'(ANG_TWO_PI);
    st_nxt.neg = 1'b0;
    if (a > ANG_W'(ANG_HALF_PI)) begin
      a = ANG_W'(ANG_PI) - a;
      st_nxt.neg = 1'b1;
    end else if (a < -ANG_W'(ANG_HALF_PI)) begin
      a = -ANG_W'(ANG_PI) - a;
      st_nxt.neg = 1'b1;
    end
    st_nxt.x = CORDIC_GAIN;
    st_nxt.y = '0;
    // folded angle fits 20 signed bits; scale Q3.16 to Q2.30
    st_nxt.z = $signed({a[19:0], 14'd0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      st_r   <= st_nxt;
    end
  end

  assign st = st_r;

endmodule

// File: rtl/spp_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
module spp_cordic
  import spp_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic             clk,
  input  logic             en,
  input  cstate_t          st_in,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);

  cstate_t stg_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    cstate_t cur;
    cstate_t nxt;
    if (i == 0) begin : g_head
      assign cur = st_in;
    end else begin : g_tail
      assign cur = stg_r[i-1];
    end
    always_comb begin
      nxt.neg = cur.neg;
      if (!cur.z[CW-1]) begin
        nxt.x = cur.x - (cur.y >>> i);
        nxt.y = cur.y + (cur.x >>> i);
        nxt.z = cur.z - atan_q30(i);
      end else begin
        nxt.x = cur.x + (cur.y >>> i);
        nxt.y = cur.y - (cur.x >>> i);
        nxt.z = cur.z + atan_q30(i);
      end
    end
    always_ff @(posedge clk) begin
      if (en) stg_r[i] <= nxt;
    end
  end

  assign sin_o = to_unit(stg_r[STEPS-1].y);
  assign cos_o = to_unit(stg_r[STEPS-1].neg ? -stg_r[STEPS-1].x : stg_r[STEPS-1].x);

endmodule

// File: rtl/spp_combine.sv
// Direction products, radius scaling, center add and saturation (four stages).
module spp_combine
  import spp_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] sa,
  input  logic signed [15:0] ca,
  input  logic signed [15:0] sp,
  input  logic signed [15:0] cp,
  input  logic [47:0]        nrm,
  input  logic [47:0]        ax1,
  input  logic [47:0]        ax2,
  input  logic [62:0]        ctr,
  input  logic [19:0]        rad,
  output logic [62:0]        pts,
  output logic               clip
);

  logic signed [31:0] pca_r, psa_r;
  logic signed [15:0] sp_r;
  logic signed [27:0] dir_r [3];
  logic signed [38:0] sc_r [3];
  logic [62:0]        pts_r;
  logic               clip_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pca_r <= cp * ca;
      psa_r <= cp * sa;
      sp_r  <= sp;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_ax
    logic signed [49:0] sum;
    logic signed [49:0] dr;
    logic signed [38:0] pr;
    logic signed [38:0] p;
    always_comb begin
      sum = 50'(pca_r * $signed(nrm[16*k +: 16]))
          + 50'(psa_r * $signed(ax1[16*k +: 16]))
          + (50'(sp_r * $signed(ax2[16*k +: 16])) <<< 14);
      dr  = (sum + (50'sd1 <<< 27)) >>> 28;
      pr  = (sc_r[k] + 39'sd8192) >>> 14;
      p   = pr + 39'($signed(ctr[21*k +: 21]));
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dir_r[k] <= dr[27:0];
        sc_r[k]  <= 39'(dir_r[k] * $signed({1'b0, rad}));
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (p > 39'sd1048575) pts_r[21*k +: 21] <= 21'h0FFFFF;
        else if (p < -39'sd1048576) pts_r[21*k +: 21] <= 21'h100000;
        else pts_r[21*k +: 21] <= p[20:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clip_r <= (sc_r[0] + 39'sd8192 >>> 14) + 39'($signed(ctr[20:0])) > 39'sd1048575
             || (sc_r[0] + 39'sd8192 >>> 14) + 39'($signed(ctr[20:0])) < -39'sd1048576
             || (sc_r[1] + 39'sd8192 >>> 14) + 39'($signed(ctr[41:21])) > 39'sd1048575
             || (sc_r[1] + 39'sd8192 >>> 14) + 39'($signed(ctr[41:21])) < -39'sd1048576
             || (sc_r[2] + 39'sd8192 >>> 14) + 39'($signed(ctr[62:42])) > 39'sd1048575
             || (sc_r[2] + 39'sd8192 >>> 14) + 39'($signed(ctr[62:42])) < -39'sd1048576;
    end
  end

  assign pts  = pts_r;
  assign clip = clip_r;

endmodule

// File: rtl/spherical_patch_point.sv
// Top level: spherical patch point pipeline with config registers and output skid.
//  channel | dir | fields
//  in_     | in  | tdata: azimuth_fraction[16:0], polar_fraction[33:17]
//  out_    | out | tdata: point_x[20:0], point_y[41:21], point_z[62:42]; tuser: clipped
//  cfg_    | in  | wr_en, index, 63-bit data
// Registered path from input accept to out_tvalid: angle stages, CORDIC stage chain, combine
// stages; one item per cycle while the pipeline is not stalled.
// rst_n clears valid bits and config registers synchronously.
// The pipeline advances unless the two-entry skid buffer is full and the last stage
// holds an item; tready depends on registers only.
module spherical_patch_point
  import spp_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // azimuth_fraction, polar_fraction
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // point_x, point_y, point_z
  output logic        out_tuser,  // clipped
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [62:0] cfg_data
);

  localparam int LAT = CORDIC_STEPS + 6;

  logic [62:0] ctr_r;
  logic [47:0] nrm_r, ax1_r, ax2_r;
  logic [19:0] rad_r;
  logic [18:0] aze_r;
  logic [17:0] poe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0; nrm_r <= '0; ax1_r <= '0; ax2_r <= '0;
      rad_r <= '0; aze_r <= '0; poe_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CENTER: ctr_r <= cfg_data;
        REG_NORMAL: nrm_r <= cfg_data[47:0];
        REG_AXIS1:  ax1_r <= cfg_data[47:0];
        REG_AXIS2:  ax2_r <= cfg_data[47:0];
        REG_RADIUS: rad_r <= cfg_data[19:0];
        REG_AZ_EXT: aze_r <= cfg_data[18:0];
        REG_PO_EXT: poe_r <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  logic [LAT-1:0] vld_r;
  logic [1:0]     cnt_r;
  logic           en;
  logic [63:0]    sk_data_r [2];
  logic           sk_user_r [2];
  logic           rd_r;

  // stall only when skid is full and the last stage holds an item
  assign en        = (cnt_r != 2'd2) || !vld_r[LAT-1];
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
  end

  cstate_t st_az, st_po;
  logic signed [15:0] sa, ca, sp, cp;
  logic [62:0] pts;
  logic clip;

  spp_angle #(.EXT_W(19)) u_ang_az (
    .clk(clk), .en(en), .frac(in_tdata[16:0]), .ext(aze_r), .st(st_az));
  spp_angle #(.EXT_W(19)) u_ang_po (
    .clk(clk), .en(en), .frac(in_tdata[33:17]), .ext({1'b0, poe_r}), .st(st_po));
  spp_cordic #(.STEPS(CORDIC_STEPS)) u_cor_az (
    .clk(clk), .en(en), .st_in(st_az), .sin_o(sa), .cos_o(ca));
  spp_cordic #(.STEPS(CORDIC_STEPS)) u_cor_po (
    .clk(clk), .en(en), .st_in(st_po), .sin_o(sp), .cos_o(cp));
  spp_combine u_comb (
    .clk(clk), .en(en), .sa(sa), .ca(ca), .sp(sp), .cp(cp),
    .nrm(nrm_r), .ax1(ax1_r), .ax2(ax2_r), .ctr(ctr_r), .rad(rad_r),
    .pts(pts), .clip(clip));

  logic push, pop;
  assign push = en && vld_r[LAT-1];
  assign pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
      if (pop) rd_r <= !rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      sk_data_r[rd_r ^ (cnt_r == 2'd1)] <= {1'b0, pts};
      sk_user_r[rd_r ^ (cnt_r == 2'd1)] <= clip;
    end
  end

  assign out_tvalid = cnt_r != 2'd0;
  assign out_tdata  = sk_data_r[rd_r];
  assign out_tuser  = sk_user_r[rd_r];

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("skid overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |-> !push) else $error("push into full skid");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r)) else $error("pipeline moved while stalled");

endmodule
